>>> rtl/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants of the sorted insertion set.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int FUNC_W   = 2;
  localparam int STAT_W   = 3;
  localparam int POS_W    = 5;
  localparam int OCNT_W   = 5;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_DUMP   = 2'd1,
    FN_CLEAR  = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_ENTRY    = 3'd3,
    STAT_EMPTY    = 3'd4,
    STAT_CLEARED  = 3'd5
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic insert_en;  // open a slot and drop the new value into it
    logic rotate_en;  // hand every value one cell toward the head
    logic occ;        // cell holds a live entry
    logic wrap;       // cell is the last live one: takes the head value
  } cell_ctl_t;

endpackage

>>> rtl/ssi_if.sv
// ----------------------------------------------------------------------------
// ssi_in_if / ssi_out_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface ssi_in_if import ssi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface ssi_out_if import ssi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] entry_value;
  logic [OCNT_W-1:0]       count;
  logic                    last;

  modport source (output valid, output status, output position, output entry_value,
                  output count, output last, input ready);
  modport sink   (input valid, input status, input position, input entry_value,
                  input count, input last, output ready);
endinterface

>>> rtl/ssi_cell.sv
// ----------------------------------------------------------------------------
// ssi_cell
// One slot of the sorted chain: compare against the new value, shift or rotate.
// ----------------------------------------------------------------------------
module ssi_cell import ssi_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  val_t      new_val,
  input  val_t      prev_val,
  input  logic      prev_lt,
  input  val_t      next_val,
  input  val_t      head_val,
  output val_t      val,
  output logic      lt,
  output logic      eq
);

  val_t val_r;
  val_t val_nxt;

  assign val = val_r;
  assign lt  = ctl.occ && (val_r < new_val);
  assign eq  = ctl.occ && (val_r == new_val);

  always_comb begin
    val_nxt = val_r;
    if (ctl.insert_en && !lt) begin
      // first cell not below the new value takes it, the rest move up
      val_nxt = prev_lt ? new_val : prev_val;
    end else if (ctl.rotate_en) begin
      val_nxt = ctl.wrap ? head_val : next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

>>> rtl/sorted_set_insert.sv
// ----------------------------------------------------------------------------
// sorted_set_insert
// Ordered set of distinct signed values kept in a chain of compare/shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one operation item: func (insert, dump, clear) and value.
//   out_ch carries result items; each item's final result has last set.
//   Insert: every cell compares its value with the new one in
//   parallel; the cells at and above the sorted slot shift up one place and
//   the slot takes the value. A full store or an equal value refuses it.
//   Clear: one result. Dump of an empty store: one result.
//   Dump of N entries: N results at one per cycle while out_ch is ready. The
//   chain rotates toward cell 0 once per result, cell 0 feeds the output, and
//   after N steps the order is back where it started. Input is held off
//   during a dump. The result sits in an output register from the cycle after
//   acceptance. A new item is taken in the same cycle that the waiting result
//   leaves, so single-result items run at one per cycle; a stalled receiver
//   holds the result register and, with it, the input and the dump sequencer.
//   Reset (rst_n low at a clock edge) empties the store and drops any
//   pending result; cell contents are left as they are.
// ----------------------------------------------------------------------------
module sorted_set_insert import ssi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ssi_in_if.sink    in_ch,
  ssi_out_if.source out_ch
);

  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;
  cnt_t   idx_r, idx_nxt;

  logic                  out_valid_r;
  logic [STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [POS_W-1:0]      out_pos_r, out_pos_nxt;
  val_t                  out_val_r, out_val_nxt;
  logic [OCNT_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  emit;

  logic insert_en, rotate_en;
  logic in_fire, out_free;
  logic full, dup, dump_end;
  cnt_t ins_pos;
  val_t in_val;

  val_t             cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;

  assign in_val   = in_ch.value;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign full     = (cnt_r >= cnt_t'(CAPACITY));
  assign dup      = |cell_eq;
  assign dump_end = (idx_r == cnt_r - cnt_t'(1));

  // cells below the slot form a prefix of lt bits; slot is the first clear one
  always_comb begin
    ins_pos = cnt_t'(CAPACITY);
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!cell_lt[i]) begin
        ins_pos = cnt_t'(i);
      end
    end
  end

  // ---- chain of cells ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t ctl;
    val_t      prev_val;
    val_t      next_val;
    logic      prev_lt;

    assign ctl.insert_en = insert_en;
    assign ctl.rotate_en = rotate_en;
    assign ctl.occ       = (cnt_t'(i) < cnt_r);
    assign ctl.wrap      = (cnt_t'(i) == cnt_r - cnt_t'(1));

    if (i == 0) begin : g_first
      assign prev_val = in_val;
      assign prev_lt  = 1'b0;
    end else begin : g_mid
      assign prev_val = cell_val[i-1];
      assign prev_lt  = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_val = cell_val[0];
    end else begin : g_body
      assign next_val = cell_val[i+1];
    end

    ssi_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .new_val  (in_val),
      .prev_val (prev_val),
      .prev_lt  (prev_lt),
      .next_val (next_val),
      .head_val (cell_val[0]),
      .val      (cell_val[i]),
      .lt       (cell_lt[i]),
      .eq       (cell_eq[i])
    );
  end

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_ch.func == FN_DUMP) && (cnt_r > cnt_t'(1))) begin
          state_nxt = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (out_free && dump_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---- outputs of the sequencer ----
  always_comb begin
    emit           = 1'b0;
    insert_en      = 1'b0;
    rotate_en      = 1'b0;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_val_nxt    = out_val_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_last_nxt = 1'b1;
          case (in_ch.func)
            FN_INSERT: begin
              emit        = 1'b1;
              out_val_nxt = in_val;
              if (full) begin
                out_status_nxt = STAT_FULL;
                out_pos_nxt    = '0;
                out_cnt_nxt    = OCNT_W'(cnt_r);
              end else if (dup) begin
                out_status_nxt = STAT_DUP;
                out_pos_nxt    = POS_W'(ins_pos);
                out_cnt_nxt    = OCNT_W'(cnt_r);
              end else begin
                insert_en      = 1'b1;
                cnt_nxt        = cnt_r + cnt_t'(1);
                out_status_nxt = STAT_INSERTED;
                out_pos_nxt    = POS_W'(ins_pos);
                out_cnt_nxt    = OCNT_W'(cnt_r + cnt_t'(1));
              end
            end
            FN_DUMP: begin
              emit        = 1'b1;
              out_pos_nxt = '0;
              if (cnt_r == '0) begin
                out_status_nxt = STAT_EMPTY;
                out_val_nxt    = '0;
                out_cnt_nxt    = '0;
              end else begin
                // first entry leaves now; advance the rotation
                rotate_en      = 1'b1;
                idx_nxt        = cnt_t'(1);
                out_status_nxt = STAT_ENTRY;
                out_val_nxt    = cell_val[0];
                out_cnt_nxt    = OCNT_W'(cnt_r);
                out_last_nxt   = (cnt_r == cnt_t'(1));
              end
            end
            FN_CLEAR: begin
              emit           = 1'b1;
              cnt_nxt        = '0;
              out_status_nxt = STAT_CLEARED;
              out_pos_nxt    = '0;
              out_val_nxt    = '0;
              out_cnt_nxt    = '0;
            end
            default: begin
              // unused code: drop the item
              emit = 1'b0;
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          emit           = 1'b1;
          rotate_en      = 1'b1;
          idx_nxt        = idx_r + cnt_t'(1);
          out_status_nxt = STAT_ENTRY;
          out_pos_nxt    = POS_W'(idx_r);
          out_val_nxt    = cell_val[0];
          out_cnt_nxt    = OCNT_W'(cnt_r);
          out_last_nxt   = dump_end;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the payload until the next result replaces it
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_val_r    <= out_val_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.position    = out_pos_r;
  assign out_ch.entry_value = out_val_r;
  assign out_ch.count       = out_cnt_r;
  assign out_ch.last        = out_last_r;

endmodule
